@@ hdl/dual_format_packet_receiver_top_defines.svh @@
// Assertion macros used by the packet receiver top level.
`ifndef DUAL_FORMAT_PACKET_RECEIVER_TOP_DEFINES_SVH
`define DUAL_FORMAT_PACKET_RECEIVER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DFPR_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dfpr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DFPR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dfpr: next-cycle check failed");

`endif

@@ hdl/dfpr_pkg.sv @@
// Package with the constants and types of the dual-format packet receiver.
`default_nettype none

package dfpr_pkg;

   // Default packet sizes.
   localparam int BIN_LEN_DEF  = 4;
   localparam int TEXT_MAX_DEF = 16;

   // At most this many results are streamed for one packet.
   localparam int MAX_RESULTS = 16;
   localparam int POS_W       = 4;

   // Framing bytes.
   localparam logic [7:0] BIN_HEAD  = 8'hFF;
   localparam logic [7:0] BIN_TAIL  = 8'hFE;
   localparam logic [7:0] TEXT_HEAD = 8'h40;
   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;

   // Kind of a result.
   typedef enum logic [1:0] {
      KIND_BIN  = 2'd0,
      KIND_TEXT = 2'd1,
      KIND_OVF  = 2'd2,
      KIND_TAKE = 2'd3
   } kind_type;

   // A burst of results raised by one accepted input.
   typedef struct packed {
      logic             valid;
      kind_type         kind;
      logic [POS_W-1:0] last_idx;
      logic             empty;
      logic             was_ready;
   } dfpr_event_type;

   // Read request into the payload stores.
   typedef struct packed {
      logic             is_text;
      logic [POS_W-1:0] idx;
   } dfpr_read_type;

endpackage

`default_nettype wire

@@ hdl/dfpr_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
`default_nettype none

interface dfpr_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface dfpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] data_byte;
   logic [3:0] position;
   logic       last;
   logic       empty_text;
   logic       was_ready;

   modport source (output valid, output result_kind, output data_byte, output position,
                   output last, output empty_text, output was_ready, input ready);
   modport sink (input valid, input result_kind, input data_byte, input position,
                 input last, input empty_text, input was_ready, output ready);
endinterface

`default_nettype wire

@@ hdl/dfpr_deframer.sv @@
// Framing state machine, payload stores and ready flag of the receiver.
`default_nettype none

module dfpr_deframer #(
   parameter int BIN_LEN  = dfpr_pkg::BIN_LEN_DEF,
   parameter int TEXT_MAX = dfpr_pkg::TEXT_MAX_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    xfer,
   input  wire logic                    cmd,
   input  wire logic [7:0]              rx_byte,
   input  wire dfpr_pkg::dfpr_read_type rd,
   output logic [7:0]                   rd_byte,
   output dfpr_pkg::dfpr_event_type     evt
);
   import dfpr_pkg::*;

   localparam int CNT_MAX  = (TEXT_MAX > BIN_LEN) ? TEXT_MAX : BIN_LEN;
   localparam int CNT_W    = $clog2(CNT_MAX + 1);
   localparam int EXT_W    = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;
   localparam int BIN_RD_N = (BIN_LEN < MAX_RESULTS) ? BIN_LEN : MAX_RESULTS;
   localparam int TXT_RD_N = (TEXT_MAX < MAX_RESULTS) ? TEXT_MAX : MAX_RESULTS;
   localparam logic [POS_W-1:0] BIN_LAST = POS_W'(BIN_RD_N - 1);

   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_COLLECT = 3'b010,
      PH_TAIL    = 3'b100
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             is_text_ff, is_text_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             flag_ff, flag_in;
   logic [7:0]       bin_store_ff [BIN_LEN];
   logic [7:0]       txt_store_ff [TEXT_MAX];
   logic             bin_we, txt_we;
   logic [CNT_W-1:0] cnt_inc, bin_cnt_next;
   logic [EXT_W-1:0] n_ext;
   logic [POS_W-1:0] txt_last;

   assign cnt_inc      = cnt_ff + CNT_W'(1);
   assign bin_cnt_next = (cnt_ff < CNT_W'(BIN_LEN)) ? cnt_inc : cnt_ff;
   assign n_ext        = EXT_W'(cnt_ff);

   // Index of the last streamed text byte, capped at the burst limit.
   always_comb begin
      if (n_ext > EXT_W'(MAX_RESULTS)) begin
         txt_last = POS_W'(MAX_RESULTS - 1);
      end else begin
         txt_last = POS_W'(n_ext - EXT_W'(1));
      end
   end

   // Next state of the framer for an accepted transfer.
   always_comb begin
      phase_in   = phase_ff;
      is_text_in = is_text_ff;
      cnt_in     = cnt_ff;
      flag_in    = flag_ff;
      bin_we     = 1'b0;
      txt_we     = 1'b0;
      evt        = '0;
      if (xfer) begin
         if (cmd) begin
            evt.valid     = 1'b1;
            evt.kind      = KIND_TAKE;
            evt.was_ready = flag_ff;
            flag_in       = 1'b0;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (rx_byte == BIN_HEAD) begin
                     phase_in   = PH_COLLECT;
                     is_text_in = 1'b0;
                     cnt_in     = '0;
                  end else if (rx_byte == TEXT_HEAD && !flag_ff) begin
                     phase_in   = PH_COLLECT;
                     is_text_in = 1'b1;
                     cnt_in     = '0;
                  end
               end
               PH_COLLECT: begin
                  if (!is_text_ff) begin
                     bin_we = (cnt_ff < CNT_W'(BIN_LEN));
                     cnt_in = bin_cnt_next;
                     if (bin_cnt_next >= CNT_W'(BIN_LEN)) begin
                        phase_in = PH_TAIL;
                     end
                  end else if (rx_byte == CHAR_CR) begin
                     phase_in = PH_TAIL;
                  end else if (cnt_ff >= CNT_W'(TEXT_MAX)) begin
                     // Too many characters: report and drop the packet.
                     cnt_in    = '0;
                     phase_in  = PH_IDLE;
                     evt.valid = 1'b1;
                     evt.kind  = KIND_OVF;
                  end else begin
                     txt_we = 1'b1;
                     cnt_in = cnt_inc;
                  end
               end
               PH_TAIL: begin
                  if (!is_text_ff) begin
                     if (rx_byte == BIN_TAIL) begin
                        flag_in      = 1'b1;
                        phase_in     = PH_IDLE;
                        cnt_in       = '0;
                        evt.valid    = 1'b1;
                        evt.kind     = KIND_BIN;
                        evt.last_idx = BIN_LAST;
                     end
                  end else if (rx_byte != CHAR_LF) begin
                     // A stray byte after CR is dropped and collection resumes.
                     phase_in = PH_COLLECT;
                  end else begin
                     flag_in   = 1'b1;
                     phase_in  = PH_IDLE;
                     cnt_in    = '0;
                     evt.valid = 1'b1;
                     evt.kind  = KIND_TEXT;
                     if (cnt_ff == '0) begin
                        evt.empty = 1'b1;
                     end else begin
                        evt.last_idx = txt_last;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         is_text_ff <= 1'b0;
         cnt_ff     <= '0;
         flag_ff    <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         is_text_ff <= is_text_in;
         cnt_ff     <= cnt_in;
         flag_ff    <= flag_in;
      end
   end

   // Payload stores, written at the running byte count.
   always_ff @(posedge clock) begin
      for (int i = 0; i < BIN_LEN; i++) begin
         if (bin_we && cnt_ff == CNT_W'(i)) begin
            bin_store_ff[i] <= rx_byte;
         end
      end
      for (int i = 0; i < TEXT_MAX; i++) begin
         if (txt_we && cnt_ff == CNT_W'(i)) begin
            txt_store_ff[i] <= rx_byte;
         end
      end
   end

   // Read port used by the result streamer.
   always_comb begin
      rd_byte = '0;
      if (rd.is_text) begin
         for (int i = 0; i < TXT_RD_N; i++) begin
            if (rd.idx == POS_W'(i)) begin
               rd_byte = txt_store_ff[i];
            end
         end
      end else begin
         for (int i = 0; i < BIN_RD_N; i++) begin
            if (rd.idx == POS_W'(i)) begin
               rd_byte = bin_store_ff[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/dfpr_streamer.sv @@
// Burst sequencer and result register of the packet receiver.
`default_nettype none

module dfpr_streamer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire dfpr_pkg::dfpr_event_type evt,
   output logic                          in_ready,
   output dfpr_pkg::dfpr_read_type       rd,
   input  wire logic [7:0]               rd_byte,
   dfpr_rsp_if.source                    rsp
);
   import dfpr_pkg::*;

   logic             job_active_ff, job_active_in;
   kind_type         job_kind_ff, job_kind_in;
   logic [POS_W-1:0] job_idx_ff, job_idx_in;
   logic [POS_W-1:0] job_last_ff, job_last_in;
   logic             job_empty_ff, job_empty_in;
   logic             job_wr_ff, job_wr_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff;
   logic [7:0]       rsp_data_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_last_ff;
   logic             rsp_empty_ff;
   logic             rsp_wr_ff;

   logic out_free, load, job_done, is_payload;

   // The result register takes a new entry when empty or being drained.
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign load       = job_active_ff && out_free;
   assign job_done   = load && (job_idx_ff == job_last_ff);
   assign in_ready   = !job_active_ff || job_done;
   assign is_payload = (job_kind_ff inside {KIND_BIN, KIND_TEXT}) && !job_empty_ff;

   assign rd.is_text = (job_kind_ff == KIND_TEXT);
   assign rd.idx     = job_idx_ff;

   // Burst bookkeeping: a new burst replaces one that finishes this cycle.
   always_comb begin
      job_active_in = job_active_ff;
      job_kind_in   = job_kind_ff;
      job_idx_in    = job_idx_ff;
      job_last_in   = job_last_ff;
      job_empty_in  = job_empty_ff;
      job_wr_in     = job_wr_ff;
      if (evt.valid) begin
         job_active_in = 1'b1;
         job_kind_in   = evt.kind;
         job_idx_in    = '0;
         job_last_in   = evt.last_idx;
         job_empty_in  = evt.empty;
         job_wr_in     = evt.was_ready;
      end else if (job_done) begin
         job_active_in = 1'b0;
      end else if (load) begin
         job_idx_in = job_idx_ff + POS_W'(1);
      end
   end

   assign rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         job_active_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         job_active_ff <= job_active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Burst descriptor and result payload.
   always_ff @(posedge clock) begin
      job_kind_ff  <= job_kind_in;
      job_idx_ff   <= job_idx_in;
      job_last_ff  <= job_last_in;
      job_empty_ff <= job_empty_in;
      job_wr_ff    <= job_wr_in;
      if (load) begin
         rsp_kind_ff  <= job_kind_ff;
         rsp_data_ff  <= is_payload ? rd_byte : 8'd0;
         rsp_pos_ff   <= is_payload ? job_idx_ff : '0;
         rsp_last_ff  <= (job_idx_ff == job_last_ff);
         rsp_empty_ff <= job_empty_ff;
         rsp_wr_ff    <= (job_kind_ff == KIND_TAKE) ? job_wr_ff : 1'b0;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.data_byte   = rsp_data_ff;
   assign rsp.position    = rsp_pos_ff;
   assign rsp.last        = rsp_last_ff;
   assign rsp.empty_text  = rsp_empty_ff;
   assign rsp.was_ready   = rsp_wr_ff;

endmodule

`default_nettype wire

@@ hdl/dual_format_packet_receiver_top.sv @@
// Dual-format packet receiver: binary and text packet deframer.
//
// Request channel (req_chan): one transfer per received byte (cmd = 0) or per
// take command (cmd = 1). Result channel (rsp_chan): payload bytes of each
// completed packet, one per transfer, with last set on the final one; an empty
// text packet, an overflow report or a take reply is a single transfer.
// An accepted item changes the framing state at once; its first result passes
// through the burst descriptor register into the result register when the
// receiver is not stalling. A completed packet yields up to 16 results, one per
// cycle while the receiver is not stalling; the request side stays ready while
// no burst is pending and takes the next item in the same cycle as a burst's
// last result is loaded, so bytes that cause no burst are taken every cycle.
// A stalling receiver holds the result register; the sequencer then waits and,
// with a burst pending, the request side drops ready until it is fully loaded.
// Reset (synchronous, active high) returns the framer to waiting for a header,
// clears the ready flag and empties the result register. Payload stores hold
// no reset value; only bytes of the current packet are ever sent.
`default_nettype none
`include "dual_format_packet_receiver_top_defines.svh"

module dual_format_packet_receiver_top #(
   parameter int BIN_LEN  = dfpr_pkg::BIN_LEN_DEF,
   parameter int TEXT_MAX = dfpr_pkg::TEXT_MAX_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   dfpr_req_if.sink   req_chan,
   dfpr_rsp_if.source rsp_chan
);
   import dfpr_pkg::*;

   logic           req_xfer;
   logic           in_ready;
   logic [7:0]     rd_byte;
   dfpr_event_type evt;
   dfpr_read_type  rd;

   assign req_chan.ready = in_ready;
   assign req_xfer       = req_chan.valid && in_ready;

   // Framing logic and payload stores.
   dfpr_deframer #(
      .BIN_LEN  (BIN_LEN),
      .TEXT_MAX (TEXT_MAX)
   ) u_deframer (
      .clock   (clock),
      .reset   (reset),
      .xfer    (req_xfer),
      .cmd     (req_chan.cmd),
      .rx_byte (req_chan.rx_byte),
      .rd      (rd),
      .rd_byte (rd_byte),
      .evt     (evt)
   );

   // Result sequencing and output register.
   dfpr_streamer u_streamer (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt),
      .in_ready (in_ready),
      .rd       (rd),
      .rd_byte  (rd_byte),
      .rsp      (rsp_chan)
   );

   // Checks on the event path and the result stream.
   `DFPR_ASSERT_SAME(a_evt_needs_xfer, evt.valid, req_xfer)
   `DFPR_ASSERT_SAME(a_take_gives_reply, req_xfer && req_chan.cmd,
                     evt.valid && evt.kind == KIND_TAKE)
   `DFPR_ASSERT_SAME(a_single_is_last, rsp_chan.valid && (rsp_chan.result_kind == KIND_TAKE ||
                     rsp_chan.result_kind == KIND_OVF), rsp_chan.last && rsp_chan.position == '0)
   `DFPR_ASSERT_NEXT(a_burst_blocks, evt.valid && evt.last_idx != '0, !req_chan.ready)

endmodule

`default_nettype wire

@@ bench/dual_format_packet_receiver_top_tb.sv @@
// Self-checking testbench for the dual-format packet receiver: directed cases, then random traffic.
`timescale 1ns / 100ps

module dual_format_packet_receiver_top_tb;
   import dfpr_pkg::*;

   // Framing phase of the local packet tracker.
   typedef enum logic [2:0] {
      FRAME_HUNT    = 3'b001,
      FRAME_COLLECT = 3'b010,
      FRAME_TAIL    = 3'b100
   } frame_phase_type;

   // One result transfer as it should appear on the result channel.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [3:0] position;
      logic       last;
      logic       empty_text;
      logic       was_ready;
   } rsp_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dfpr_req_if req_chan ();
   dfpr_rsp_if rsp_chan ();

   dual_format_packet_receiver_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Local copy of the framing state.
   frame_phase_type frame_phase    = FRAME_HUNT;
   logic            frame_is_text  = 1'b0;
   int unsigned     frame_count    = 0;
   logic            packet_waiting = 1'b0;
   logic [7:0]      bin_payload  [BIN_LEN_DEF];
   logic [7:0]      text_payload [TEXT_MAX_DEF];

   // Results still owed by the block, oldest first.
   rsp_item_type deframed_q [$];

   int          mismatches     = 0;
   int          items_sent     = 0;
   int          send_idle_pct  = 0;
   int          rsp_stall_pct  = 0;
   int unsigned cycle_no       = 0;
   int unsigned hold_end_cycle = 0;

   function automatic void queue_result(kind_type k, logic [7:0] d, logic [3:0] p,
                                        logic l, logic e, logic w);
      rsp_item_type it;
      it.kind       = k;
      it.data_byte  = d;
      it.position   = p;
      it.last       = l;
      it.empty_text = e;
      it.was_ready  = w;
      deframed_q.push_back(it);
   endfunction

   // A completed packet streams its payload, capped at the burst limit.
   function automatic void release_payload(kind_type k, int unsigned n);
      int unsigned cnt;
      logic [7:0]  d;
      cnt = (n > MAX_RESULTS) ? MAX_RESULTS : n;
      for (int unsigned i = 0; i < cnt; i++) begin
         d = (k == KIND_BIN) ? bin_payload[i] : text_payload[i];
         queue_result(k, d, i[3:0], (i + 1 == cnt), 1'b0, 1'b0);
      end
   endfunction

   // Advance the framing state by one accepted transfer and queue its results.
   function automatic void deframe_item(logic c, logic [7:0] b);
      int unsigned n;
      if (c) begin
         queue_result(KIND_TAKE, 8'h00, 4'd0, 1'b1, 1'b0, packet_waiting);
         packet_waiting = 1'b0;
         return;
      end
      case (frame_phase)
         FRAME_HUNT: begin
            if (b == BIN_HEAD) begin
               frame_phase   = FRAME_COLLECT;
               frame_is_text = 1'b0;
               frame_count   = 0;
            end else if (b == TEXT_HEAD && !packet_waiting) begin
               frame_phase   = FRAME_COLLECT;
               frame_is_text = 1'b1;
               frame_count   = 0;
            end
         end
         FRAME_COLLECT: begin
            if (!frame_is_text) begin
               if (frame_count < BIN_LEN_DEF) begin
                  bin_payload[frame_count] = b;
                  frame_count++;
               end
               if (frame_count >= BIN_LEN_DEF)
                  frame_phase = FRAME_TAIL;
            end else if (b == CHAR_CR) begin
               frame_phase = FRAME_TAIL;
            end else if (frame_count >= TEXT_MAX_DEF) begin
               // Text overflow: report once and go back to hunting.
               frame_count = 0;
               frame_phase = FRAME_HUNT;
               queue_result(KIND_OVF, 8'h00, 4'd0, 1'b1, 1'b0, 1'b0);
            end else begin
               text_payload[frame_count] = b;
               frame_count++;
            end
         end
         FRAME_TAIL: begin
            if (!frame_is_text) begin
               // Anything but the tail byte is ignored here.
               if (b == BIN_TAIL) begin
                  packet_waiting = 1'b1;
                  frame_phase    = FRAME_HUNT;
                  frame_count    = 0;
                  release_payload(KIND_BIN, BIN_LEN_DEF);
               end
            end else if (b != CHAR_LF) begin
               // The byte after CR is dropped unless it is LF.
               frame_phase = FRAME_COLLECT;
            end else begin
               n              = frame_count;
               packet_waiting = 1'b1;
               frame_phase    = FRAME_HUNT;
               frame_count    = 0;
               if (n == 0)
                  queue_result(KIND_TEXT, 8'h00, 4'd0, 1'b1, 1'b1, 1'b0);
               else
                  release_payload(KIND_TEXT, n);
            end
         end
         default: frame_phase = FRAME_HUNT;
      endcase
   endfunction

   function automatic logic [7:0] random_byte_except(logic [7:0] banned);
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == banned);
      return b;
   endfunction

   task automatic check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $error("%s: expected %0d, got %0d", name, exp, act);
         mismatches++;
      end
   endtask

   // Cycle counter that times the receiver hold-off.
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   // Result side: check each transfer, then decide whether to stall next cycle.
   initial begin
      rsp_item_type front;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (deframed_q.size() == 0) begin
               $error("result transfer with nothing pending: kind %0d, data %0d",
                      rsp_chan.result_kind, rsp_chan.data_byte);
               mismatches++;
            end else begin
               front = deframed_q.pop_front();
               check_field("result_kind", front.kind, rsp_chan.result_kind);
               check_field("data_byte", front.data_byte, rsp_chan.data_byte);
               check_field("position", front.position, rsp_chan.position);
               check_field("last", front.last, rsp_chan.last);
               check_field("empty_text", front.empty_text, rsp_chan.empty_text);
               check_field("was_ready", front.was_ready, rsp_chan.was_ready);
            end
         end
         rsp_chan.ready <= (cycle_no < hold_end_cycle) ? 1'b0
                                                       : ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Offer one item, with random idle cycles ahead of it, and wait for the transfer.
   task automatic send_rx_item(input logic c, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.cmd     <= c;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      deframe_item(c, b);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_rx_item(1'b0, b);
   endtask

   task automatic send_take();
      send_rx_item(1'b1, 8'($urandom_range(255)));
   endtask

   // The sender pauses until every owed result has been received.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      while (deframed_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_binary_packet();
      send_byte(BIN_HEAD);
      repeat (BIN_LEN_DEF)
         send_byte(8'($urandom_range(255)));
      // Now and then some junk sits between the payload and the tail.
      repeat (($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0)
         send_byte(random_byte_except(BIN_TAIL));
      send_byte(BIN_TAIL);
   endtask

   // Text packet with len stored characters; a stray CR plus a dropped byte may be mixed in.
   task automatic send_text_packet(input int len);
      send_byte(TEXT_HEAD);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            send_byte(CHAR_CR);
            send_byte(random_byte_except(CHAR_LF));
         end
         send_byte(random_byte_except(CHAR_CR));
      end
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   // One well-formed sequence with random content, or some noise.
   task automatic random_step();
      int pick;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_binary_packet();
      end else if (pick < 65) begin
         if ($urandom_range(4) != 0)
            send_take();
         send_text_packet($urandom_range(0, TEXT_MAX_DEF + 1));
      end else if (pick < 80) begin
         send_take();
      end else if (pick < 90) begin
         // A header followed by a packet that is cut short.
         send_byte(pick[0] ? BIN_HEAD : TEXT_HEAD);
         repeat ($urandom_range(0, 3))
            send_byte(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic run_random(input int send_pct, input int stall_pct, input int quota);
      int target;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      target        = items_sent + quota;
      while (items_sent < target)
         random_step();
   endtask

   // Directed framing cases: extremes, the tail rule, the ready flag and text corner cases.
   task automatic test_framing_cases();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      send_take();
      send_byte(8'h00);
      send_byte(CHAR_LF);
      send_byte(BIN_HEAD);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h5A);
      send_byte(BIN_TAIL);
      // A text header is ignored while a packet waits to be taken.
      send_byte(TEXT_HEAD);
      send_byte(8'h41);
      send_take();
      send_take();
      send_byte(TEXT_HEAD);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
      send_take();
      send_byte(TEXT_HEAD);
      send_byte(8'h61);
      send_byte(CHAR_CR);
      send_byte(8'h78);
      send_byte(8'hFF);
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
   endtask

   // The receiver holds off for a long stretch so the block fills and stalls its input.
   task automatic test_receiver_hold_off();
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      hold_end_cycle = cycle_no + 400;
      repeat (3)
         send_binary_packet();
      send_take();
      send_text_packet(TEXT_MAX_DEF);
      send_take();
      send_text_packet(TEXT_MAX_DEF + 1);
      send_take();
      wait_for_results();
   endtask

   task automatic test_back_to_back();
      run_random(0, 0, 75);
   endtask

   task automatic test_sparse_sender();
      run_random(81, 0, 75);
   endtask

   task automatic test_slow_receiver();
      run_random(0, 81, 75);
   endtask

   task automatic test_both_sides_idle();
      run_random(17, 17, 75);
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.cmd     = 1'b0;
      req_chan.rx_byte = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_framing_cases();
      test_receiver_hold_off();
      test_back_to_back();
      test_sparse_sender();
      test_slow_receiver();
      test_both_sides_idle();

      wait_for_results();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hdl
hdl/dfpr_pkg.sv
hdl/dfpr_if.sv
hdl/dfpr_deframer.sv
hdl/dfpr_streamer.sv
hdl/dual_format_packet_receiver_top.sv
bench/dual_format_packet_receiver_top_tb.sv
